// File: sv/rgba_ab_pkg.sv
`default_nettype none

package rgba_ab_pkg;

    // pixel layout: red 63:48, green 47:32, blue 31:16, alpha 15:0
    localparam int CHAN_W   = 16;
    localparam int PIX_W    = 64;
    localparam int COLOR_CH = 3;
    localparam int PROD_W   = 2 * CHAN_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int CFG_W    = 5;

    localparam logic [CHAN_W-1:0] ALPHA_FULL  = 16'hFFFF;
    localparam logic [CHAN_W-1:0] ALPHA_ZERO  = 16'h0000;
    localparam logic [SUM_W-1:0]  ROUND_HALF  = 33'h0_0000_8000;
    localparam logic [CFG_W-1:0]  DEPTH_10    = 5'd10;
    localparam logic [CFG_W-1:0]  DEPTH_12    = 5'd12;
    localparam logic [CFG_W-1:0]  DEPTH_RESET = 5'd16;

    // control that travels with each pipeline word
    typedef struct packed {
        logic valid;
        logic pass;
    } t_ctl;

    // products of one blended word
    typedef struct packed {
        logic [COLOR_CH-1:0][PROD_W-1:0] src_a;
        logic [COLOR_CH-1:0][PROD_W-1:0] dst_inv;
        logic [PROD_W-1:0]               da_inv;
    } t_prod;

endpackage

`default_nettype wire

// File: sv/rgba_ab_mul.sv
`default_nettype none

module rgba_ab_mul (
    input  wire                                logic i_clk,
    input  wire                                logic i_rst_n,
    input  wire  rgba_ab_pkg::t_ctl                  i_ctl,
    input  wire  logic [rgba_ab_pkg::PIX_W-1:0]      i_dst,
    input  wire  logic [rgba_ab_pkg::PIX_W-1:0]      i_src,
    input  wire  logic [rgba_ab_pkg::PIX_W-1:0]      i_pass_pix,
    output rgba_ab_pkg::t_ctl                        o_ctl,
    output rgba_ab_pkg::t_prod                       o_prod,
    output logic [rgba_ab_pkg::CHAN_W-1:0]           o_alpha,
    output logic [rgba_ab_pkg::PIX_W-1:0]            o_pass_pix
);

    localparam int CW = rgba_ab_pkg::CHAN_W;
    localparam int PW = rgba_ab_pkg::PROD_W;

    logic [CW-1:0]        alpha;
    logic [CW-1:0]        inv;
    rgba_ab_pkg::t_prod   n_prod;
    rgba_ab_pkg::t_prod   r_prod;
    rgba_ab_pkg::t_ctl    r_ctl;
    logic [CW-1:0]        r_alpha;
    logic [rgba_ab_pkg::PIX_W-1:0] r_pass_pix;

    assign alpha = i_src[CW-1:0];
    assign inv   = rgba_ab_pkg::ALPHA_FULL - alpha;

    // one 16x16 multiply per term, color lanes side by side
    always_comb begin
        for (int i = 0; i < rgba_ab_pkg::COLOR_CH; i++) begin
            n_prod.src_a[i]   = PW'(i_src[(i+1)*CW +: CW]) * PW'(alpha);
            n_prod.dst_inv[i] = PW'(i_dst[(i+1)*CW +: CW]) * PW'(inv);
        end
        n_prod.da_inv = PW'(i_dst[CW-1:0]) * PW'(inv);
    end

    // control word, valid and pass bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_prod       <= n_prod;
        r_alpha      <= alpha;
        r_pass_pix   <= i_pass_pix;
    end

    assign o_ctl      = r_ctl;
    assign o_prod     = r_prod;
    assign o_alpha    = r_alpha;
    assign o_pass_pix = r_pass_pix;

endmodule

`default_nettype wire

// File: sv/rgba_ab_mix.sv
`default_nettype none

module rgba_ab_mix (
    input  wire                                logic i_clk,
    input  wire                                logic i_rst_n,
    input  wire  logic [rgba_ab_pkg::CFG_W-1:0]      i_channel_bits,
    input  wire  rgba_ab_pkg::t_ctl                  i_ctl,
    input  wire  rgba_ab_pkg::t_prod                 i_prod,
    input  wire  logic [rgba_ab_pkg::CHAN_W-1:0]     i_alpha,
    input  wire  logic [rgba_ab_pkg::PIX_W-1:0]      i_pass_pix,
    output logic                                     o_done,
    output logic [rgba_ab_pkg::PIX_W-1:0]            o_out_pixel
);

    localparam int CW = rgba_ab_pkg::CHAN_W;
    localparam int SW = rgba_ab_pkg::SUM_W;

    logic [CW-1:0]                 mask;
    logic [SW-1:0]                 sum;
    logic [SW-1:0]                 asum;
    logic [rgba_ab_pkg::PIX_W-1:0] blend;
    logic [rgba_ab_pkg::PIX_W-1:0] n_out_pixel;
    logic [rgba_ab_pkg::PIX_W-1:0] r_out_pixel;
    logic                          r_done;

    // depth mask for blended channels
    always_comb begin
        if (i_channel_bits == rgba_ab_pkg::DEPTH_10) begin
            mask = 16'h03FF;
        end else if (i_channel_bits == rgba_ab_pkg::DEPTH_12) begin
            mask = 16'h0FFF;
        end else begin
            mask = 16'hFFFF;
        end
    end

    // rounded sums, alpha accumulate, mask, pass select
    always_comb begin
        sum   = '0;
        blend = '0;
        for (int i = 0; i < rgba_ab_pkg::COLOR_CH; i++) begin
            sum = SW'(i_prod.src_a[i]) + SW'(i_prod.dst_inv[i]) + rgba_ab_pkg::ROUND_HALF;
            blend[(i+1)*CW +: CW] = sum[2*CW-1:CW] & mask;
        end
        asum = SW'(i_prod.da_inv) + rgba_ab_pkg::ROUND_HALF;
        blend[CW-1:0] = (i_alpha + asum[2*CW-1:CW]) & mask;
        n_out_pixel = i_ctl.pass ? i_pass_pix : blend;
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        r_out_pixel <= n_out_pixel;
    end

    assign o_done      = r_done;
    assign o_out_pixel = r_out_pixel;

endmodule

`default_nettype wire

// File: sv/rgba16_alpha_blend.sv
// Source-over blender for 64-bit pixels with 16-bit channels (red 63:48,
// green 47:32, blue 31:16, alpha 15:0). A pixel pair is taken on every
// clock where i_start is high; o_busy is always low. Each result appears
// on o_out_pixel with o_done high for one cycle, once the pair has passed
// the three-stage pipeline (input register, multiply register, sum and mask
// register), which sustains one pixel per clock. Results
// cannot be held off by the receiver. A source alpha of 0 passes the
// destination and 0xFFFF passes the source unchanged; otherwise a depth of
// 10 or 12 in channel_bits masks every blended channel to that many bits.
// channel_bits is written through the cfg channel, which is always ready.
`default_nettype none

module rgba16_alpha_blend (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic [rgba_ab_pkg::PIX_W-1:0]     i_dst_pixel,
    input  wire logic [rgba_ab_pkg::PIX_W-1:0]     i_src_pixel,
    output logic                                   o_done,
    output logic [rgba_ab_pkg::PIX_W-1:0]          o_out_pixel,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rgba_ab_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW = rgba_ab_pkg::CHAN_W;
    localparam int PXW = rgba_ab_pkg::PIX_W;

    logic [rgba_ab_pkg::CFG_W-1:0] r_channel_bits;
    rgba_ab_pkg::t_ctl             r_s1_ctl;
    logic [PXW-1:0]                r_s1_dst;
    logic [PXW-1:0]                r_s1_src;
    logic [PXW-1:0]                r_s1_pass_pix;
    logic [PXW-1:0]                n_s1_pass_pix;
    logic                          n_s1_pass;
    logic [CW-1:0]                 src_alpha;
    rgba_ab_pkg::t_ctl             s2_ctl;
    rgba_ab_pkg::t_prod            s2_prod;
    logic [CW-1:0]                 s2_alpha;
    logic [PXW-1:0]                s2_pass_pix;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // depth register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_bits <= rgba_ab_pkg::DEPTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_channel_bits <= i_cfg_data;
        end
    end

    // pass-through decode on the source alpha
    assign src_alpha = i_src_pixel[CW-1:0];
    always_comb begin
        n_s1_pass     = 1'b1;
        n_s1_pass_pix = i_src_pixel;
        if (src_alpha == rgba_ab_pkg::ALPHA_ZERO) begin
            n_s1_pass_pix = i_dst_pixel;
        end else if (src_alpha != rgba_ab_pkg::ALPHA_FULL) begin
            n_s1_pass = 1'b0;
        end
    end

    // input stage control, valid and pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl.valid <= i_start && !o_busy;
            r_s1_ctl.pass  <= n_s1_pass;
        end
    end

    // input stage word
    always_ff @(posedge i_clk) begin
        r_s1_dst      <= i_dst_pixel;
        r_s1_src      <= i_src_pixel;
        r_s1_pass_pix <= n_s1_pass_pix;
    end

    rgba_ab_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_s1_ctl),
        .i_dst      (r_s1_dst),
        .i_src      (r_s1_src),
        .i_pass_pix (r_s1_pass_pix),
        .o_ctl      (s2_ctl),
        .o_prod     (s2_prod),
        .o_alpha    (s2_alpha),
        .o_pass_pix (s2_pass_pix)
    );

    rgba_ab_mix u_mix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_channel_bits (r_channel_bits),
        .i_ctl          (s2_ctl),
        .i_prod         (s2_prod),
        .i_alpha        (s2_alpha),
        .i_pass_pix     (s2_pass_pix),
        .o_done         (o_done),
        .o_out_pixel    (o_out_pixel)
    );

endmodule

`default_nettype wire

// File: sv/rgba_ab_chk.sv
`default_nettype none

module rgba_ab_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_start,
    input wire logic                          o_busy,
    input wire logic [rgba_ab_pkg::PIX_W-1:0] i_dst_pixel,
    input wire logic [rgba_ab_pkg::PIX_W-1:0] i_src_pixel,
    input wire logic                          o_done,
    input wire logic [rgba_ab_pkg::PIX_W-1:0] o_out_pixel
);

    localparam int CW = rgba_ab_pkg::CHAN_W;

    // every accepted word gives one result
    a_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_done)
        else $error("accepted word produced no result");

    // no result without an accepted word
    a_done_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 3))
        else $error("result without an accepted word");

    // transparent source leaves the destination untouched
    a_pass_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_src_pixel[CW-1:0] == rgba_ab_pkg::ALPHA_ZERO)
        |-> ##3 (o_out_pixel == $past(i_dst_pixel, 3)))
        else $error("transparent source altered the destination");

    // opaque source replaces the destination
    a_pass_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_src_pixel[CW-1:0] == rgba_ab_pkg::ALPHA_FULL)
        |-> ##3 (o_out_pixel == $past(i_src_pixel, 3)))
        else $error("opaque source not passed");

endmodule

bind rgba16_alpha_blend rgba_ab_chk u_rgba_ab_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_dst_pixel (i_dst_pixel),
    .i_src_pixel (i_src_pixel),
    .o_done      (o_done),
    .o_out_pixel (o_out_pixel)
);

`default_nettype wire

// File: verif/tb_rgba16_alpha_blend.sv
`default_nettype none

module tb_rgba16_alpha_blend;

    localparam int QUIET_LIMIT = 300;
    localparam int SETTLE_CYCLES = 8;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    logic [rgba_ab_pkg::PIX_W-1:0] i_dst_pixel;
    logic [rgba_ab_pkg::PIX_W-1:0] i_src_pixel;
    logic                          o_done;
    logic [rgba_ab_pkg::PIX_W-1:0] o_out_pixel;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [rgba_ab_pkg::CFG_W-1:0] i_cfg_data;

    // expected result words, oldest first
    logic [rgba_ab_pkg::PIX_W-1:0] pending_pixels[$];
    logic [rgba_ab_pkg::PIX_W-1:0] want_pixel;
    logic [rgba_ab_pkg::CFG_W-1:0] channel_depth;
    int                            mismatch_count;
    int                            quiet_cycles;
    int                            idle_pct;
    logic                          progress;

    rgba16_alpha_blend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_dst_pixel (i_dst_pixel),
        .i_src_pixel (i_src_pixel),
        .o_done      (o_done),
        .o_out_pixel (o_out_pixel),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 unit clock period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // source-over blend of one pixel pair at the given display depth
    function automatic logic [rgba_ab_pkg::PIX_W-1:0] blend_pixel(
        input logic [rgba_ab_pkg::PIX_W-1:0] dst,
        input logic [rgba_ab_pkg::PIX_W-1:0] src,
        input logic [rgba_ab_pkg::CFG_W-1:0] depth);
        logic [rgba_ab_pkg::CHAN_W-1:0] alpha;
        logic [33:0]                    a_w;
        logic [33:0]                    inv_w;
        logic [33:0]                    s_w;
        logic [33:0]                    d_w;
        logic [33:0]                    acc;
        logic [rgba_ab_pkg::CHAN_W:0]   alpha_sum;
        logic [rgba_ab_pkg::CHAN_W-1:0] mask;
        logic [rgba_ab_pkg::PIX_W-1:0]  res;
        int                             ch;
        alpha = src[rgba_ab_pkg::CHAN_W-1:0];
        if (alpha == rgba_ab_pkg::ALPHA_ZERO)
            return dst;
        if (alpha == rgba_ab_pkg::ALPHA_FULL)
            return src;
        a_w = 34'(alpha);
        inv_w = 34'(rgba_ab_pkg::ALPHA_FULL - alpha);
        res = '0;
        // red, green, blue
        for (ch = 1; ch < 4; ch++) begin
            s_w = 34'(src[rgba_ab_pkg::CHAN_W*ch +: rgba_ab_pkg::CHAN_W]);
            d_w = 34'(dst[rgba_ab_pkg::CHAN_W*ch +: rgba_ab_pkg::CHAN_W]);
            acc = s_w * a_w + d_w * inv_w + 34'h8000;
            res[rgba_ab_pkg::CHAN_W*ch +: rgba_ab_pkg::CHAN_W] = acc[31:16];
        end
        // alpha accumulates, kept to 16 bits
        d_w = 34'(dst[rgba_ab_pkg::CHAN_W-1:0]);
        acc = d_w * inv_w + 34'h8000;
        alpha_sum = 17'(alpha) + 17'(acc[31:16]);
        res[rgba_ab_pkg::CHAN_W-1:0] = alpha_sum[rgba_ab_pkg::CHAN_W-1:0];
        // only 10 and 12 bit displays truncate blended channels
        if (depth == rgba_ab_pkg::DEPTH_10 || depth == rgba_ab_pkg::DEPTH_12) begin
            mask = ~(16'hFFFF << depth);
            res = res & {4{mask}};
        end
        return res;
    endfunction

    // result check, expectation capture, config tracking and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            channel_depth = rgba_ab_pkg::DEPTH_RESET;
            quiet_cycles = 0;
        end else begin
            progress = 1'b0;
            if (o_done) begin
                progress = 1'b1;
                if (pending_pixels.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected out_pixel word, expected none, got %h",
                             $time, o_out_pixel);
                end else begin
                    want_pixel = pending_pixels.pop_front();
                    if (o_out_pixel !== want_pixel) begin
                        mismatch_count++;
                        $display("%0t: out_pixel mismatch, expected %h, got %h",
                                 $time, want_pixel, o_out_pixel);
                    end
                end
            end
            if (i_start && !o_busy) begin
                progress = 1'b1;
                pending_pixels.push_back(blend_pixel(i_dst_pixel, i_src_pixel, channel_depth));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                progress = 1'b1;
                channel_depth = i_cfg_data;
            end
            if (progress)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: timeout, %0d words still expected", $time, pending_pixels.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // send one pixel pair, idling cycle by cycle at the current idle share
    task automatic send_pair(input logic [rgba_ab_pkg::PIX_W-1:0] dst,
                             input logic [rgba_ab_pkg::PIX_W-1:0] src);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_start = 1'b0;
        end
        @(negedge i_clk);
        i_start = 1'b1;
        i_dst_pixel = dst;
        i_src_pixel = src;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    // stop sending and wait for every expected word
    task automatic wait_for_results();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // write channel_bits while the pipe is empty
    task automatic set_channel_depth(input logic [rgba_ab_pkg::CFG_W-1:0] depth);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = depth;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // alpha 0 and full alpha at reset depth
    task automatic test_pass_through();
        send_pair(64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_FFFF_0000);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_FFFF);
        send_pair(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // blended path near the alpha and channel extremes
    task automatic test_blend_extremes();
        send_pair(64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_0001);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_FFFE);
        send_pair(64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_8000);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
        send_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_7FFF);
    endtask

    // masking at 10 and 12 bits, never on the pass paths; other depths unmasked
    task automatic test_depth_mask();
        set_channel_depth(rgba_ab_pkg::DEPTH_10);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_8000);
        send_pair(64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_FFFF_0000);
        send_pair(64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        set_channel_depth(rgba_ab_pkg::DEPTH_12);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_4000);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
        send_pair(64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        set_channel_depth(5'd11);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_8000);
        set_channel_depth(5'd0);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_8000);
        set_channel_depth(5'd31);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_8000);
        set_channel_depth(5'd1);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_8000);
    endtask

    // random pairs in blocks, new depth between blocks
    task automatic test_random_traffic(input int pct, input int count);
        logic [rgba_ab_pkg::PIX_W-1:0] dst;
        logic [rgba_ab_pkg::PIX_W-1:0] src;
        logic [rgba_ab_pkg::CFG_W-1:0] depth;
        int                            n;
        idle_pct = pct;
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(3))
                    0: depth = rgba_ab_pkg::DEPTH_10;
                    1: depth = rgba_ab_pkg::DEPTH_12;
                    2: depth = rgba_ab_pkg::DEPTH_RESET;
                    default: depth = 5'($urandom_range(31));
                endcase
                set_channel_depth(depth);
            end
            dst = {$urandom, $urandom};
            src = {$urandom, $urandom};
            // pull some channels to the rails
            case ($urandom_range(7))
                0: dst = '1;
                1: dst = '0;
                2: src[63:16] = '1;
                3: src[63:16] = '0;
                default: ;
            endcase
            // bias alpha toward the pass values and their neighbors
            case ($urandom_range(9))
                0: src[15:0] = rgba_ab_pkg::ALPHA_ZERO;
                1: src[15:0] = rgba_ab_pkg::ALPHA_FULL;
                2: src[15:0] = 16'($urandom_range(1, 15));
                3: src[15:0] = rgba_ab_pkg::ALPHA_FULL - 16'($urandom_range(1, 15));
                default: ;
            endcase
            send_pair(dst, src);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_dst_pixel = '0;
        i_src_pixel = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        channel_depth = rgba_ab_pkg::DEPTH_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_pass_through();
        test_blend_extremes();
        test_depth_mask();
        test_random_traffic(32, 170);
        test_random_traffic(70, 160);
        test_random_traffic(0, 170);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
sv/rgba_ab_pkg.sv
sv/rgba_ab_mul.sv
sv/rgba_ab_mix.sv
sv/rgba16_alpha_blend.sv
sv/rgba_ab_chk.sv
verif/tb_rgba16_alpha_blend.sv
